[rtl/core/bpc_pkg.sv]
// Shared types and constants for the button short/long press classifier.
// Used by bpc_lane, bpc_merge and button_short_long_press_classifier.
package bpc_pkg;

  localparam int unsigned NumButtons   = 3;
  localparam int unsigned CfgDataWidth = 16;
  localparam int unsigned CfgIdxWidth  = 2;
  localparam int unsigned CountWidth   = 16;
  localparam int unsigned LongWidth    = 16;
  localparam int unsigned DebWidth     = 8;

  localparam logic [LongWidth-1:0] LongTicksReset = LongWidth'(1000);
  localparam logic [DebWidth-1:0]  DebounceReset  = DebWidth'(25);

  typedef enum logic [CfgIdxWidth-1:0] {
    RegLongEnable = 2'd0,
    RegLongTicks  = 2'd1,
    RegDebounce   = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [NumButtons-1:0] raw_pressed;
    logic [NumButtons-1:0] take_short;
    logic [NumButtons-1:0] take_long;
  } in_item_t;

  typedef struct packed {
    logic [NumButtons-1:0] short_pressed;
    logic [NumButtons-1:0] long_pressed;
    logic [NumButtons-1:0] debounced_level;
  } out_item_t;

  // Per-lane control for one tick
  typedef struct packed {
    logic accept;
    logic started;
  } lane_ctrl_t;

  // Shared timing configuration seen by every lane
  typedef struct packed {
    logic [LongWidth-1:0] long_ticks;
    logic [DebWidth-1:0]  debounce;
  } lane_cfg_t;

  // What one lane reports for the current tick
  typedef struct packed {
    logic short_pressed;
    logic long_pressed;
    logic level;
  } lane_res_t;

endpackage

[rtl/core/bpc_lane.sv]
// One button lane: lockout debounce, hold counter and short/long flags.
// Depends on bpc_pkg.
module bpc_lane (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bpc_pkg::lane_ctrl_t ctrl_i,
  input  bpc_pkg::lane_cfg_t  cfg_i,
  input  logic               long_en_i,
  input  logic               raw_i,
  input  logic               take_short_i,
  input  logic               take_long_i,
  output bpc_pkg::lane_res_t  res_o
);
  import bpc_pkg::*;

  logic                  level_q, level_d;
  logic [CountWidth-1:0] cnt_q, cnt_d;
  logic                  short_q, short_d;
  logic                  long_q, long_d;
  logic                  seen_q, seen_d;
  logic                  ignore_q, ignore_d;

  logic [CountWidth-1:0] cnt_inc;
  logic                  released;
  logic                  is_long;

  always_comb begin
    level_d  = level_q;
    cnt_d    = cnt_q;
    short_d  = short_q & ~take_short_i;
    long_d   = long_q & ~take_long_i;
    seen_d   = seen_q;
    ignore_d = ignore_q;
    released = 1'b0;
    is_long  = 1'b0;
    cnt_inc  = (cnt_q == {CountWidth{1'b1}}) ? cnt_q : cnt_q + CountWidth'(1);

    if (!ctrl_i.started) begin
      // first tick: adopt the pin level, ignore a button already held
      level_d  = raw_i;
      cnt_d    = '0;
      ignore_d = raw_i;
      seen_d   = 1'b0;
    end else begin
      cnt_d = cnt_inc;
      if (cnt_inc >= CountWidth'(cfg_i.debounce) && raw_i != level_q) begin
        level_d  = raw_i;
        cnt_d    = '0;
        released = ~raw_i;
      end
      is_long = long_en_i && level_d && (cnt_d >= CountWidth'(cfg_i.long_ticks));
      if (is_long) begin
        if (!ignore_q) begin
          long_d = 1'b1;
          seen_d = 1'b1;
        end
      end else if (released) begin
        if (seen_q || ignore_q) begin
          seen_d   = 1'b0;
          ignore_d = 1'b0;
        end else begin
          short_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q  <= 1'b0;
      cnt_q    <= '0;
      short_q  <= 1'b0;
      long_q   <= 1'b0;
      seen_q   <= 1'b0;
      ignore_q <= 1'b0;
    end else if (ctrl_i.accept) begin
      level_q  <= level_d;
      cnt_q    <= cnt_d;
      short_q  <= short_d;
      long_q   <= long_d;
      seen_q   <= seen_d;
      ignore_q <= ignore_d;
    end
  end

  // flags as they stood before this tick's clear, level after the tick
  assign res_o.short_pressed = short_q;
  assign res_o.long_pressed  = long_q;
  assign res_o.level         = level_d;

endmodule

[rtl/core/bpc_merge.sv]
// Merging stage: gathers the lane results into one result item and holds
// it in the output register until the consumer takes it. Depends on bpc_pkg.
module bpc_merge (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_i,
  input  bpc_pkg::lane_res_t [bpc_pkg::NumButtons-1:0] lane_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output bpc_pkg::out_item_t            out_data_o,
  output logic                          free_o
);
  import bpc_pkg::*;

  logic      valid_q, valid_d;
  out_item_t data_q, data_d;

  always_comb begin
    for (int i = 0; i < NumButtons; i++) begin
      data_d.short_pressed[i]   = lane_i[i].short_pressed;
      data_d.long_pressed[i]    = lane_i[i].long_pressed;
      data_d.debounced_level[i] = lane_i[i].level;
    end
  end

  // register can take a new item when empty or being drained this cycle
  assign free_o  = ~valid_q | out_ready_i;
  assign valid_d = load_i | (valid_q & ~out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

[rtl/core/button_short_long_press_classifier.sv]
// Top level of the debounced button short/long press classifier.
// Depends on bpc_pkg, bpc_lane and bpc_merge.
//
//   channel  | signals                          | moves
//   ---------+----------------------------------+-------------------------
//   in       | in_valid_i in_ready_o in_data_i  | one tick item per transfer
//   out      | out_valid_o out_ready_i out_data_o | one result per tick
//   cfg      | cfg_we_i cfg_idx_i cfg_data_i    | register write, no wait
//
// One tick item is taken per clock while input ready is high; its result appears
// in the output register on the next cycle. All lanes update in the cycle of the transfer.
// Input ready drops only while the output register is full and not taken.
// Reset clears all button state; the first tick after reset loads the levels.
module button_short_long_press_classifier (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  bpc_pkg::in_item_t                     in_data_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output bpc_pkg::out_item_t                    out_data_o,
  input  logic                                  cfg_we_i,
  input  logic [bpc_pkg::CfgIdxWidth-1:0]       cfg_idx_i,
  input  logic [bpc_pkg::CfgDataWidth-1:0]      cfg_data_i
);
  import bpc_pkg::*;

  logic [NumButtons-1:0] long_en_q;
  lane_cfg_t             cfg_q;
  logic                  started_q;
  logic                  accept;
  logic                  free;
  lane_ctrl_t            ctrl;
  lane_res_t [NumButtons-1:0] lane_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_en_q        <= '0;
      cfg_q.long_ticks <= LongTicksReset;
      cfg_q.debounce   <= DebounceReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegLongEnable: long_en_q        <= cfg_data_i[NumButtons-1:0];
        RegLongTicks:  cfg_q.long_ticks <= cfg_data_i[LongWidth-1:0];
        RegDebounce:   cfg_q.debounce   <= cfg_data_i[DebWidth-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready_o   = free;
  assign accept       = in_valid_i & free;
  assign ctrl.accept  = accept;
  assign ctrl.started = started_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
    end else if (accept) begin
      started_q <= 1'b1;
    end
  end

  for (genvar g = 0; g < NumButtons; g++) begin : g_lane
    bpc_lane u_lane (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .cfg_i       (cfg_q),
      .long_en_i   (long_en_q[g]),
      .raw_i       (in_data_i.raw_pressed[g]),
      .take_short_i(in_data_i.take_short[g]),
      .take_long_i (in_data_i.take_long[g]),
      .res_o       (lane_res[g])
    );
  end

  bpc_merge u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (accept),
    .lane_i     (lane_res),
    .out_ready_i(out_ready_i),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o),
    .free_o     (free)
  );

endmodule
